// ===== sv/rmc_pkg.sv =====
// ----------------------------------------------------------------------------
// rmc_pkg
// Shared types and constants for the radiation memory convolution core.
// ----------------------------------------------------------------------------
package rmc_pkg;

    localparam int NUM_AXES   = 6;
    localparam int AXIS_W     = 3;
    localparam int FORCE_W    = 48;
    localparam int TS_W       = 32;
    localparam int CHUNK_W    = 32;
    // The scaled sum carries 60 fractional bits and the force keeps 8.
    localparam int FRAC_SHIFT = 52;
    localparam int ROUND_BIT  = 51;

    localparam logic [FORCE_W-1:0] SAT_POS = 48'h7FFF_FFFF_FFFF;
    localparam logic [FORCE_W-1:0] SAT_NEG = 48'h8000_0000_0000;
    localparam logic [TS_W-1:0]    TS_RESET = 32'd42949673;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_LOAD   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_SCALE_GO,
        ST_SCALE_WAIT,
        ST_PUSH
    } core_state_t;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_MUL,
        SC_ADD,
        SC_RND,
        SC_SAT
    } scale_state_t;

    typedef struct packed {
        logic                acc_clr;
        logic                issue;
        logic [AXIS_W-1:0]   axis;
    } lane_ctrl_t;

endpackage

// ===== sv/rmc_ram.sv =====
// ----------------------------------------------------------------------------
// rmc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/rmc_lane.sv =====
// ----------------------------------------------------------------------------
// rmc_lane
// One output axis: six kernel memories, a multiplier and an accumulator.
// ----------------------------------------------------------------------------
module rmc_lane
    import rmc_pkg::*;
#(
    parameter int TAPS        = 256,
    parameter int ACCEL_WIDTH = 32,
    parameter int COEF_WIDTH  = 32,
    parameter int ACC_W       = 75
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [NUM_AXES-1:0]                    wr_mask,
    input  logic [$clog2(TAPS)-1:0]                wr_addr,
    input  logic [COEF_WIDTH-1:0]                  wr_data,
    input  logic [$clog2(TAPS)-1:0]                rd_addr,
    input  lane_ctrl_t                             ctrl,
    input  logic [NUM_AXES-1:0][ACCEL_WIDTH-1:0]   hist_data,
    output logic signed [ACC_W-1:0]                acc
);

    localparam int PW = ACCEL_WIDTH + COEF_WIDTH;

    logic [NUM_AXES-1:0][COEF_WIDTH-1:0] kern_data;
    logic                    v1_reg;
    logic [AXIS_W-1:0]       axis1_reg;
    logic                    v2_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [PW-1:0]    prod_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACCEL_WIDTH-1:0] hsel;
    logic signed [COEF_WIDTH-1:0]  ksel;

    for (genvar j = 0; j < NUM_AXES; j++)
    begin : g_kern
        rmc_ram #(.WIDTH(COEF_WIDTH), .DEPTH(TAPS)) u_ram (
            .clk   (clk),
            .we    (wr_mask[j]),
            .waddr (wr_addr),
            .wdata (wr_data),
            .raddr (rd_addr),
            .rdata (kern_data[j])
        );
    end

    always_comb
    begin
        hsel      = hist_data[axis1_reg];
        ksel      = kern_data[axis1_reg];
        prod_next = hsel * ksel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctrl.issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        axis1_reg <= ctrl.axis;
        prod_reg  <= prod_next;
        if (ctrl.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + {{(ACC_W-PW){prod_reg[PW-1]}}, prod_reg};
        end
    end

    assign acc = acc_reg;

endmodule

// ===== sv/rmc_scale.sv =====
// ----------------------------------------------------------------------------
// rmc_scale
// Multiplies one lane sum by the time step 32 bits at a time, then rounds
// and saturates to the force format.
// ----------------------------------------------------------------------------
module rmc_scale
    import rmc_pkg::*;
#(
    parameter int ACC_W = 75
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] acc_in,
    input  logic [TS_W-1:0]         time_step,
    output logic                    done,
    output logic [FORCE_W-1:0]      result
);

    localparam int MAG_W = ACC_W + 1;
    localparam int NCH   = (MAG_W + CHUNK_W - 1) / CHUNK_W;
    localparam int PADW  = NCH * CHUNK_W;
    localparam int RW    = PADW + 96;
    localparam int QW    = RW - FRAC_SHIFT;
    localparam int CW    = (NCH > 1) ? $clog2(NCH) : 1;

    scale_state_t              state_reg, state_next;
    logic                      neg_reg, neg_next;
    logic [PADW-1:0]           mag_reg, mag_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [2*CHUNK_W-1:0]      prod_reg, prod_next;
    logic [RW-1:0]             r_reg, r_next;
    logic [FORCE_W-1:0]        res_reg, res_next;
    logic                      done_reg, done_next;
    logic [MAG_W-1:0]          ext;
    logic [MAG_W-1:0]          mag_abs;
    logic [QW-1:0]             q;
    logic                      big;

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        r_next     = r_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        ext        = {acc_in[ACC_W-1], acc_in};
        // The magnitude is formed at the extended sum width, then zero-padded.
        mag_abs    = acc_in[ACC_W-1] ? (~ext + 1'b1) : ext;
        q          = r_reg[RW-1:FRAC_SHIFT];
        big        = |q[QW-1:FORCE_W-1];
        case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    neg_next   = acc_in[ACC_W-1];
                    mag_next   = PADW'(mag_abs);
                    cnt_next   = CW'(NCH - 1);
                    r_next     = '0;
                    state_next = SC_MUL;
                end
            end
            SC_MUL:
            begin
                prod_next  = (2*CHUNK_W)'(mag_reg[cnt_reg*CHUNK_W +: CHUNK_W])
                           * (2*CHUNK_W)'(time_step);
                state_next = SC_ADD;
            end
            SC_ADD:
            begin
                r_next = (r_reg << CHUNK_W) + RW'(prod_reg);
                if (cnt_reg == '0)
                begin
                    state_next = SC_RND;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = SC_MUL;
                end
            end
            SC_RND:
            begin
                // Half an output LSB, so the truncation rounds ties away from zero.
                r_next     = r_reg + (RW'(1) << ROUND_BIT);
                state_next = SC_SAT;
            end
            SC_SAT:
            begin
                if (neg_reg)
                begin
                    res_next = big ? SAT_NEG : (~q[FORCE_W-1:0] + 1'b1);
                end
                else
                begin
                    res_next = big ? SAT_POS : q[FORCE_W-1:0];
                end
                done_next  = 1'b1;
                state_next = SC_IDLE;
            end
            default:
            begin
                state_next = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
        r_reg    <= r_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== sv/radiation_memory_convolution_core.sv =====
// ----------------------------------------------------------------------------
// radiation_memory_convolution_core
// Six-input, six-output FIR convolution of acceleration history with
// radiation kernels, scaled by the time step.
// ----------------------------------------------------------------------------
// Usage: a request on the input channel (in_valid, in_stall) is either a
// coefficient load (mode 1) or an acceleration sample (mode 0). A load is
// written in the cycle it is taken and gives no result. A sample gives one
// result on the output channel (out_valid, out_stall) with six forces.
// A sample runs six lanes, one per output axis, over taps 1 to TAPS-1 of
// each input axis in turn, one kernel tap each cycle and lane. The lane
// pipelines then drain, and one shared scaling unit rounds the lanes one
// after another. The first sample after reset gives zero forces. The
// time step is written through cfg_we / cfg_data. After reset the core
// clears its kernel and history memories with in_stall high. A finished
// result waits in the output register while out_stall is high; the next
// request is taken meanwhile, but a new result waits until the register
// is free.
// ----------------------------------------------------------------------------
module radiation_memory_convolution_core
    import rmc_pkg::*;
#(
    parameter int TAPS        = 256,
    parameter int ACCEL_WIDTH = 32,
    parameter int COEF_WIDTH  = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [TS_W-1:0]    cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic signed [31:0] accel_surge,
    input  logic signed [31:0] accel_sway,
    input  logic signed [31:0] accel_heave,
    input  logic signed [31:0] accel_roll,
    input  logic signed [31:0] accel_pitch,
    input  logic signed [31:0] accel_yaw,
    input  logic [2:0]         load_out_axis,
    input  logic [2:0]         load_in_axis,
    input  logic [7:0]         load_tap,
    input  logic signed [31:0] load_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [FORCE_W-1:0] force_surge,
    output logic signed [FORCE_W-1:0] force_sway,
    output logic signed [FORCE_W-1:0] force_heave,
    output logic signed [FORCE_W-1:0] moment_roll,
    output logic signed [FORCE_W-1:0] moment_pitch,
    output logic signed [FORCE_W-1:0] moment_yaw
);

    localparam int TAW   = $clog2(TAPS);
    localparam int ACC_W = ACCEL_WIDTH + COEF_WIDTH + $clog2(NUM_AXES * TAPS);

    core_state_t       state_reg, state_next;
    logic [TAW-1:0]    ptr_reg, ptr_next;
    logic              primed_reg, primed_next;
    logic              clearing_reg, clearing_next;
    logic [TAW:0]      clr_reg, clr_next;
    logic [TAW-1:0]    k_reg, k_next;
    logic [TAW-1:0]    slot_reg, slot_next;
    logic [AXIS_W-1:0] j_reg, j_next;
    logic [1:0]        drain_reg, drain_next;
    logic [AXIS_W-1:0] sidx_reg, sidx_next;
    logic [TS_W-1:0]   ts_reg;
    logic              out_valid_reg, out_valid_next;
    logic [NUM_AXES-1:0][FORCE_W-1:0] res_reg, res_next;
    logic [NUM_AXES-1:0][FORCE_W-1:0] out_reg, out_next;

    logic                                 accept;
    lane_ctrl_t                           ctrl;
    logic [NUM_AXES-1:0][NUM_AXES-1:0]    lane_mask;
    logic [TAW-1:0]                       kwr_addr;
    logic [COEF_WIDTH-1:0]                kwr_data;
    logic                                 hwr_en;
    logic [TAW-1:0]                       hwr_addr;
    logic [NUM_AXES-1:0][ACCEL_WIDTH-1:0] hwr_data;
    logic [NUM_AXES-1:0][ACCEL_WIDTH-1:0] accel_in;
    logic [NUM_AXES-1:0][ACCEL_WIDTH-1:0] hist_data;
    logic signed [ACC_W-1:0]              lane_acc [NUM_AXES];
    logic                                 scale_start;
    logic                                 scale_done;
    logic [FORCE_W-1:0]                   scale_res;
    logic [TAW-1:0]                       ptr_inc;
    logic                                 load_ok;

    assign accel_in[0] = accel_surge[ACCEL_WIDTH-1:0];
    assign accel_in[1] = accel_sway[ACCEL_WIDTH-1:0];
    assign accel_in[2] = accel_heave[ACCEL_WIDTH-1:0];
    assign accel_in[3] = accel_roll[ACCEL_WIDTH-1:0];
    assign accel_in[4] = accel_pitch[ACCEL_WIDTH-1:0];
    assign accel_in[5] = accel_yaw[ACCEL_WIDTH-1:0];

    assign in_stall = clearing_reg || (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign ptr_inc  = (ptr_reg == TAW'(TAPS - 1)) ? '0 : ptr_reg + 1'b1;
    assign load_ok  = (load_out_axis < AXIS_W'(NUM_AXES))
                   && (load_in_axis < AXIS_W'(NUM_AXES))
                   && (32'(load_tap) < 32'(TAPS));

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        primed_next    = primed_reg;
        clearing_next  = clearing_reg;
        clr_next       = clr_reg;
        k_next         = k_reg;
        slot_next      = slot_reg;
        j_next         = j_reg;
        drain_next     = drain_reg;
        sidx_next      = sidx_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        ctrl           = '{acc_clr: 1'b0, issue: 1'b0, axis: j_reg};
        lane_mask      = '0;
        kwr_addr       = TAW'(load_tap);
        kwr_data       = load_value[COEF_WIDTH-1:0];
        hwr_en         = 1'b0;
        hwr_addr       = ptr_inc;
        hwr_data       = accel_in;
        scale_start    = 1'b0;

        if (clearing_reg)
        begin
            lane_mask = '1;
            kwr_addr  = clr_reg[TAW-1:0];
            kwr_data  = '0;
            hwr_en    = 1'b1;
            hwr_addr  = clr_reg[TAW-1:0];
            hwr_data  = '0;
            clr_next  = clr_reg + 1'b1;
            if (clr_reg == (TAW+1)'(TAPS - 1))
            begin
                clearing_next = 1'b0;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && mode == MODE_LOAD)
                begin
                    if (load_ok)
                    begin
                        lane_mask[load_out_axis] = NUM_AXES'(1) << load_in_axis;
                    end
                end
                else if (accept && !primed_reg)
                begin
                    // The very first sample only arms the history and gives zero forces.
                    primed_next = 1'b1;
                    res_next    = '0;
                    state_next  = ST_PUSH;
                end
                else if (accept)
                begin
                    hwr_en       = 1'b1;
                    ptr_next     = ptr_inc;
                    slot_next    = ptr_inc;
                    k_next       = TAW'(1);
                    j_next       = '0;
                    ctrl.acc_clr = 1'b1;
                    state_next   = ST_MAC;
                end
            end
            ST_MAC:
            begin
                ctrl.issue = 1'b1;
                if (k_reg == TAW'(TAPS - 1))
                begin
                    k_next    = TAW'(1);
                    slot_next = ptr_reg;
                    if (j_reg == AXIS_W'(NUM_AXES - 1))
                    begin
                        drain_next = '0;
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next    = k_reg + 1'b1;
                    slot_next = (slot_reg == '0) ? TAW'(TAPS - 1) : slot_reg - 1'b1;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'd2)
                begin
                    sidx_next  = '0;
                    state_next = ST_SCALE_GO;
                end
            end
            ST_SCALE_GO:
            begin
                scale_start = 1'b1;
                state_next  = ST_SCALE_WAIT;
            end
            ST_SCALE_WAIT:
            begin
                if (scale_done)
                begin
                    res_next[sidx_reg] = scale_res;
                    if (sidx_reg == AXIS_W'(NUM_AXES - 1))
                    begin
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        sidx_next  = sidx_reg + 1'b1;
                        state_next = ST_SCALE_GO;
                    end
                end
            end
            ST_PUSH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            primed_reg    <= 1'b0;
            clearing_reg  <= 1'b1;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            ts_reg        <= TS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            primed_reg    <= primed_next;
            clearing_reg  <= clearing_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                ts_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        slot_reg  <= slot_next;
        j_reg     <= j_next;
        drain_reg <= drain_next;
        sidx_reg  <= sidx_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        rmc_ram #(.WIDTH(ACCEL_WIDTH), .DEPTH(TAPS)) u_hist (
            .clk   (clk),
            .we    (hwr_en),
            .waddr (hwr_addr),
            .wdata (hwr_data[a]),
            .raddr (slot_reg),
            .rdata (hist_data[a])
        );

        rmc_lane #(
            .TAPS        (TAPS),
            .ACCEL_WIDTH (ACCEL_WIDTH),
            .COEF_WIDTH  (COEF_WIDTH),
            .ACC_W       (ACC_W)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr_mask   (lane_mask[a]),
            .wr_addr   (kwr_addr),
            .wr_data   (kwr_data),
            .rd_addr   (k_reg),
            .ctrl      (ctrl),
            .hist_data (hist_data),
            .acc       (lane_acc[a])
        );
    end

    rmc_scale #(.ACC_W(ACC_W)) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scale_start),
        .acc_in    (lane_acc[sidx_reg]),
        .time_step (ts_reg),
        .done      (scale_done),
        .result    (scale_res)
    );

    assign out_valid    = out_valid_reg;
    assign force_surge  = out_reg[0];
    assign force_sway   = out_reg[1];
    assign force_heave  = out_reg[2];
    assign moment_roll  = out_reg[3];
    assign moment_pitch = out_reg[4];
    assign moment_yaw   = out_reg[5];

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> in_stall)
        else $error("request taken during memory clear");

    a_mac_primed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> primed_reg)
        else $error("convolution started before first sample");

    a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH && out_valid_reg && out_stall) |=> (state_reg == ST_PUSH))
        else $error("pending result overwritten");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= TAW'(TAPS - 1))
        else $error("history pointer out of range");

endmodule

// ===== tb/radiation_memory_convolution_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radiation_memory_convolution_core_tb
// Drives coefficient loads and acceleration samples with random idle and
// stall bursts, predicts the six saturated forces of each sample in the
// testbench and compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module radiation_memory_convolution_core_tb;
    import rmc_pkg::*;

    localparam int NTAPS = 256;

    typedef struct {
        logic               mode;
        logic signed [31:0] accel [NUM_AXES];
        logic [2:0]         out_axis;
        logic [2:0]         in_axis;
        logic [7:0]         tap;
        logic signed [31:0] value;
    } request_t;

    typedef logic [NUM_AXES-1:0][FORCE_W-1:0] force_set_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [TS_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic mode = 1'b0;
    logic signed [31:0] accel [NUM_AXES] = '{default: '0};
    logic [2:0] load_out_axis = '0;
    logic [2:0] load_in_axis = '0;
    logic [7:0] load_tap = '0;
    logic signed [31:0] load_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [FORCE_W-1:0] force_out [NUM_AXES];

    // Testbench copy of the core state.
    bit signed [31:0] kernel [NUM_AXES][NUM_AXES][NTAPS];
    bit signed [31:0] history [NUM_AXES][NTAPS];
    int unsigned      head = 0;
    bit               primed = 1'b0;
    logic [TS_W-1:0]  step_scale = TS_RESET;

    request_t   pending [$];
    force_set_t force_expected [$];
    request_t   on_bus;
    int         in_gap = 0;
    int         out_gap = 0;
    bit         quiet = 1'b0;
    int         mismatches = 0;

    radiation_memory_convolution_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .accel_surge  (accel[0]),
        .accel_sway   (accel[1]),
        .accel_heave  (accel[2]),
        .accel_roll   (accel[3]),
        .accel_pitch  (accel[4]),
        .accel_yaw    (accel[5]),
        .load_out_axis(load_out_axis),
        .load_in_axis (load_in_axis),
        .load_tap     (load_tap),
        .load_value   (load_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .force_surge  (force_out[0]),
        .force_sway   (force_out[1]),
        .force_heave  (force_out[2]),
        .moment_roll  (force_out[3]),
        .moment_pitch (force_out[4]),
        .moment_yaw   (force_out[5])
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Round the exact sum times the step to 8 fractional bits, ties away from
    // zero, on the magnitude, then saturate.
    function automatic logic [FORCE_W-1:0] scale_force(logic signed [79:0] sum);
        logic          neg;
        logic [79:0]   mag;
        logic [111:0]  prod;
        logic [59:0]   q;
        neg  = sum[79];
        mag  = neg ? -sum : sum;
        prod = 112'(mag) * 112'(step_scale);
        q    = 60'((prod + (112'(1) << ROUND_BIT)) >> FRAC_SHIFT);
        if (neg)
        begin
            if (q > 60'h8000_0000_0000)
                q = 60'h8000_0000_0000;
            return FORCE_W'(-q);
        end
        if (q > 60'h7FFF_FFFF_FFFF)
            q = 60'h7FFF_FFFF_FFFF;
        return FORCE_W'(q);
    endfunction

    function automatic force_set_t convolve_sample(request_t r);
        force_set_t       f;
        logic signed [79:0] acc;
        longint           p;
        int unsigned      slot;
        f = '0;
        if (!primed)
        begin
            primed = 1'b1;
            return f;
        end
        head = (head + 1 >= NTAPS) ? 0 : head + 1;
        for (int j = 0; j < NUM_AXES; j++)
            history[j][head] = r.accel[j];
        for (int i = 0; i < NUM_AXES; i++)
        begin
            acc = '0;
            for (int j = 0; j < NUM_AXES; j++)
                for (int k = 1; k < NTAPS; k++)
                begin
                    slot = (head >= k - 1) ? head - (k - 1) : head + NTAPS - (k - 1);
                    p    = longint'(kernel[i][j][k]) * longint'(history[j][slot]);
                    acc  = acc + p;
                end
            f[i] = scale_force(acc);
        end
        return f;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            4, 5: return 32'($signed($urandom_range(0, 8192)) - 4096);
            default: return $urandom;
        endcase
    endfunction

    function automatic request_t make_load(int oa, int ia, int tp, logic [31:0] v);
        request_t r;
        r.mode = MODE_LOAD;
        foreach (r.accel[j])
            r.accel[j] = $urandom;
        r.out_axis = 3'(oa);
        r.in_axis  = 3'(ia);
        r.tap      = 8'(tp);
        r.value    = v;
        return r;
    endfunction

    function automatic request_t make_sample(logic [31:0] a);
        request_t r;
        r = make_load($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 255),
                      $urandom);
        r.mode = MODE_SAMPLE;
        foreach (r.accel[j])
            r.accel[j] = a;
        return r;
    endfunction

    // Input side: one request on the bus, held while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (on_bus.mode == MODE_LOAD)
                begin
                    if (on_bus.out_axis < NUM_AXES && on_bus.in_axis < NUM_AXES)
                        kernel[on_bus.out_axis][on_bus.in_axis][on_bus.tap] = on_bus.value;
                end
                else
                begin
                    force_expected = {force_expected, convolve_sample(on_bus)};
                end
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap = in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending.size() > 0 && !quiet && $urandom_range(0, 9) == 0)
                begin
                    in_gap = $urandom_range(0, 13);
                    in_valid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    on_bus = pending.pop_front();
                    mode          <= on_bus.mode;
                    accel         <= on_bus.accel;
                    load_out_axis <= on_bus.out_axis;
                    load_in_axis  <= on_bus.in_axis;
                    load_tap      <= on_bus.tap;
                    load_value    <= on_bus.value;
                    in_valid      <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: check each result, stall in random bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (force_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result at %0t", $realtime);
                end
                else
                begin
                    force_set_t exp_f;
                    exp_f = force_expected.pop_front();
                    for (int i = 0; i < NUM_AXES; i++)
                        if (force_out[i] !== exp_f[i])
                        begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("axis %0d: expected %h, got %h", i, exp_f[i],
                                         force_out[i]);
                        end
                end
            end
            if (out_gap > 0)
            begin
                out_gap = out_gap - 1;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_gap = $urandom_range(0, 13);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic wait_idle();
        while (pending.size() > 0 || in_valid || force_expected.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_step(logic [31:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        step_scale = v;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] steps [4];
        request_t    r;
        int          n;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: first sample is dropped, then extreme loads and samples.
        pending = {pending, make_sample(32'h8000_0000)};
        pending = {pending, make_load(0, 0, 1, 32'h7FFF_FFFF)};
        pending = {pending, make_load(0, 0, 255, 32'h8000_0000)};
        pending = {pending, make_load(5, 5, 1, 32'h8000_0000)};
        pending = {pending, make_load(1, 2, 0, 32'h0001_2345)};
        pending = {pending, make_load(6, 0, 1, 32'h7FFF_FFFF)};
        pending = {pending, make_load(0, 7, 1, 32'h7FFF_FFFF)};
        pending = {pending, make_load(2, 3, 2, 32'h0000_1000)};
        pending = {pending, make_load(3, 4, 1, 32'hFFFF_FFFF)};
        pending = {pending, make_load(4, 1, 3, 32'hFFFF_F000)};
        pending = {pending, make_sample(32'h7FFF_FFFF)};
        pending = {pending, make_sample(32'h8000_0000)};
        pending = {pending, make_sample(32'h0)};
        pending = {pending, make_sample(32'h0001_0000)};
        r = make_sample(32'h0);
        foreach (r.accel[j])
            r.accel[j] = pick_word();
        pending = {pending, r};
        pending = {pending, make_sample(32'hFFFF_0000)};
        wait_idle();

        steps[0] = 32'hFFFF_FFFF;
        steps[1] = 32'h0;
        steps[2] = $urandom;
        steps[3] = 32'h1;
        for (int ph = 0; ph < 4; ph++)
        begin
            set_step(steps[ph]);
            quiet = (ph == 3);
            n = 0;
            while (n < 94)
            begin
                if ($urandom_range(0, 9) < 6)
                begin
                    r = make_load($urandom_range(0, 9) == 0 ? $urandom_range(0, 7)
                                                             : $urandom_range(0, 5),
                                  $urandom_range(0, 9) == 0 ? $urandom_range(0, 7)
                                                             : $urandom_range(0, 5),
                                  $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                             : $urandom_range(0, 40),
                                  pick_word());
                end
                else
                begin
                    r = make_sample(32'h0);
                    foreach (r.accel[j])
                        r.accel[j] = pick_word();
                end
                pending = {pending, r};
                n++;
            end
            wait_idle();
        end

        if (mismatches == 0 && force_expected.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
